FILE: hdl/tcch_pkg.sv
// Shared types, widths and constants for the tilt-compensated compass heading block.
// No dependencies; the cell modules and the top level import this package.
package tcch_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_MODE  = 2'd0,
        REG_OFF_X = 2'd1,
        REG_OFF_Y = 2'd2,
        REG_OFF_Z = 2'd3
    } t_reg_idx;

    // square root cells: one result bit per cell
    localparam int ROOT_STEPS = 16;
    localparam int SQ_REM_W   = 31;
    localparam int SQ_ROOT_W  = 32;
    localparam int SQ_TOP_BIT = 30;

    // restoring division cells: one quotient bit per cell
    localparam int DIV_STEPS  = 16;
    localparam int DIV_REM_W  = 33;
    localparam int DIV_DEN_W  = 16;

    // pipeline registers ahead of the first CORDIC cell
    localparam int PRE_STAGES = 2 * ROOT_STEPS + DIV_STEPS + 9;

    // CORDIC datapath widths
    localparam int XW = 52;
    localparam int ZW = 27;
    localparam int AW = 24;

    // angles in units of 2^-16 degree
    localparam logic signed [ZW-1:0] Z180 = ZW'(180 * 65536);
    localparam logic signed [ZW-1:0] Z360 = ZW'(360 * 65536);

    // heading in units of 1/128 degree
    localparam logic [16:0] HEADING_WRAP = 17'd46080;
    localparam logic [24:0] ROUND_HALF   = 25'd256;

    localparam logic signed [15:0] ONE_G = 16'sd16384;

    function automatic logic [AW-1:0] atan_q16(input int idx);
        logic [AW-1:0] v;
        case (idx)
            0:  v = 24'd2949120;
            1:  v = 24'd1740967;
            2:  v = 24'd919879;
            3:  v = 24'd466945;
            4:  v = 24'd234379;
            5:  v = 24'd117304;
            6:  v = 24'd58666;
            7:  v = 24'd29335;
            8:  v = 24'd14668;
            9:  v = 24'd7334;
            10: v = 24'd3667;
            11: v = 24'd1833;
            12: v = 24'd917;
            13: v = 24'd458;
            14: v = 24'd229;
            15: v = 24'd115;
            16: v = 24'd57;
            17: v = 24'd29;
            18: v = 24'd14;
            19: v = 24'd7;
            20: v = 24'd4;
            21: v = 24'd2;
            22: v = 24'd1;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/tcch_if.sv
// Handshake channel interfaces: sample in, heading out, register writes.
// Depends on nothing; field widths follow the block's item definitions.
interface tcch_smp_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
    modport source(output valid, accel_x, accel_y, mag_x, mag_y, mag_z, input ready);
    modport sink(input valid, accel_x, accel_y, mag_x, mag_y, mag_z, output ready);
endinterface

interface tcch_hdg_if;
    logic        valid;
    logic        ready;
    logic [15:0] heading_angle;
    logic        tilt_clamped;
    modport source(output valid, heading_angle, tilt_clamped, input ready);
    modport sink(input valid, heading_angle, tilt_clamped, output ready);
endinterface

interface tcch_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

FILE: hdl/tcch_sqrt_cell.sv
// One cell of the pipelined integer square root: settles one root bit.
// Depends on tcch_pkg for datapath widths.
module tcch_sqrt_cell #(
    parameter int BIT_POS = 30
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [tcch_pkg::SQ_REM_W-1:0]  i_rem,
    input  logic [tcch_pkg::SQ_ROOT_W-1:0] i_root,
    output logic [tcch_pkg::SQ_REM_W-1:0]  o_rem,
    output logic [tcch_pkg::SQ_ROOT_W-1:0] o_root
);
    import tcch_pkg::*;

    localparam logic [SQ_ROOT_W-1:0] Bit = SQ_ROOT_W'(1) << BIT_POS;

    logic [SQ_ROOT_W-1:0] w_trial;
    logic [SQ_ROOT_W-1:0] w_rem_ext;
    logic                 w_take;
    logic [SQ_REM_W-1:0]  n_rem;
    logic [SQ_ROOT_W-1:0] n_root;
    logic [SQ_REM_W-1:0]  r_rem;
    logic [SQ_ROOT_W-1:0] r_root;

    always_comb begin
        w_trial   = i_root + Bit;
        w_rem_ext = SQ_ROOT_W'(i_rem);
        w_take    = w_rem_ext >= w_trial;
        if (w_take) begin
            n_rem  = SQ_REM_W'(w_rem_ext - w_trial);
            n_root = (i_root >> 1) + Bit;
        end else begin
            n_rem  = i_rem;
            n_root = i_root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

FILE: hdl/tcch_div_cell.sv
// One cell of the pipelined restoring divider: settles one quotient bit.
// Depends on tcch_pkg for datapath widths.
module tcch_div_cell #(
    parameter int SHIFT = 15
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [tcch_pkg::DIV_REM_W-1:0] i_rem,
    input  logic [tcch_pkg::DIV_DEN_W-1:0] i_den,
    input  logic [tcch_pkg::DIV_DEN_W-1:0] i_quo,
    output logic [tcch_pkg::DIV_REM_W-1:0] o_rem,
    output logic [tcch_pkg::DIV_DEN_W-1:0] o_den,
    output logic [tcch_pkg::DIV_DEN_W-1:0] o_quo
);
    import tcch_pkg::*;

    localparam logic [DIV_DEN_W-1:0] QBit = DIV_DEN_W'(1) << SHIFT;

    logic [DIV_REM_W-1:0] w_trial;
    logic [DIV_REM_W-1:0] n_rem;
    logic [DIV_DEN_W-1:0] n_quo;
    logic [DIV_REM_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W-1:0] r_quo;

    always_comb begin
        w_trial = DIV_REM_W'(i_den) << SHIFT;
        if (i_rem >= w_trial) begin
            n_rem = i_rem - w_trial;
            n_quo = i_quo | QBit;
        end else begin
            n_rem = i_rem;
            n_quo = i_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_den <= i_den;
            r_quo <= n_quo;
        end
    end

    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_quo = r_quo;

endmodule

FILE: hdl/tcch_cordic_cell.sv
// One CORDIC vectoring cell: rotates toward the x axis by atan(2^-IDX).
// Depends on tcch_pkg for widths and the arctangent table.
module tcch_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [tcch_pkg::XW-1:0] i_x,
    input  logic signed [tcch_pkg::XW-1:0] i_y,
    input  logic signed [tcch_pkg::ZW-1:0] i_z,
    output logic signed [tcch_pkg::XW-1:0] o_x,
    output logic signed [tcch_pkg::XW-1:0] o_y,
    output logic signed [tcch_pkg::ZW-1:0] o_z
);
    import tcch_pkg::*;

    localparam logic signed [ZW-1:0] Ang = signed'(ZW'(atan_q16(IDX)));

    logic signed [XW-1:0] w_dx;
    logic signed [XW-1:0] w_dy;
    logic signed [XW-1:0] n_x;
    logic signed [XW-1:0] n_y;
    logic signed [ZW-1:0] n_z;
    logic signed [XW-1:0] r_x;
    logic signed [XW-1:0] r_y;
    logic signed [ZW-1:0] r_z;

    always_comb begin
        w_dx = i_y >>> IDX;
        w_dy = i_x >>> IDX;
        if (!i_y[XW-1]) begin
            n_x = i_x + w_dx;
            n_y = i_y - w_dy;
            n_z = i_z + Ang;
        end else begin
            n_x = i_x - w_dx;
            n_y = i_y + w_dy;
            n_z = i_z - Ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

FILE: hdl/tilt_compensated_compass_heading.sv
// Top level of the tilt-compensated compass heading pipeline.
// Depends on tcch_pkg, tcch_if and the sqrt, divider and CORDIC cells.
//
//  port    dir  modport  carries
//  i_cfg   in   sink     register index, write data (always ready)
//  i_smp   in   sink     accel_x/y, mag_x/y/z sample item
//  o_hdg   out  source   heading_angle, tilt_clamped result item
//
// One item enters per cycle while the result is not stalled; the pipeline depth is set by the
// three 16-cell chains (pitch cosine root, roll divider, roll cosine root),
// the multiply stages and the CORDIC chain.
// i_rst_n (synchronous) clears the valid bits and the configuration registers.
// A stalled result freezes the whole pipeline; ready drops only then.
module tilt_compensated_compass_heading #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tcch_cfg_if.sink     i_cfg,
    tcch_smp_if.sink     i_smp,
    tcch_hdg_if.source   o_hdg
);
    import tcch_pkg::*;

    localparam int LAT = PRE_STAGES + CORDIC_STAGES + 2;

    // sideband that travels with an item ahead of the CORDIC chain
    typedef struct packed {
        logic                 mode;
        logic                 flag;
        logic                 ay_neg;
        logic [16:0]          num;
        logic signed [16:0]   mx;
        logic signed [16:0]   my;
        logic signed [16:0]   mz;
        logic signed [16:0]   sp;
        logic [15:0]          cp;
        logic                 sr_clamp;
        logic                 sr_zero;
        logic signed [16:0]   sr;
    } t_side;

    typedef struct packed {
        logic zero;
        logic flag;
    } t_cside;

    // ---------------- configuration registers ----------------
    logic               r_mode;
    logic signed [15:0] r_off_x;
    logic signed [15:0] r_off_y;
    logic signed [15:0] r_off_z;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_off_x <= '0;
            r_off_y <= '0;
            r_off_z <= '0;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_MODE:  r_mode  <= i_cfg.data[0];
                REG_OFF_X: r_off_x <= i_cfg.data;
                REG_OFF_Y: r_off_y <= i_cfg.data;
                REG_OFF_Z: r_off_z <= i_cfg.data;
                default:   r_mode  <= r_mode;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic w_adv;
    logic r_vld [LAT];

    // advance everything whenever the output slot is free or being taken
    assign w_adv       = !r_vld[LAT-1] || o_hdg.ready;
    assign i_smp.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_vld[k] <= 1'b0;
        end else if (w_adv) begin
            r_vld[0] <= i_smp.valid;
            for (int k = 1; k < LAT; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // ---------------- stage 0: offsets, pitch clamp ----------------
    logic               w_hi;
    logic               w_lo;
    logic signed [16:0] w_axc;
    logic signed [16:0] w_ay2;
    t_side              n_s0;
    t_side              r_s0;

    always_comb begin
        w_hi  = i_smp.accel_x > ONE_G;
        w_lo  = i_smp.accel_x < -ONE_G;
        w_axc = w_hi ? 17'sd16384 : (w_lo ? -17'sd16384
                                          : {i_smp.accel_x[15], i_smp.accel_x});
        w_ay2 = {i_smp.accel_y, 1'b0};
        n_s0          = '0;
        n_s0.mode     = r_mode;
        n_s0.flag     = r_mode && (w_hi || w_lo);
        n_s0.ay_neg   = i_smp.accel_y[15];
        n_s0.num      = i_smp.accel_y[15] ? 17'(-w_ay2) : 17'(w_ay2);
        n_s0.mx = {i_smp.mag_x[15], i_smp.mag_x} - {r_off_x[15], r_off_x};
        n_s0.my = {i_smp.mag_y[15], i_smp.mag_y} - {r_off_y[15], r_off_y};
        n_s0.mz = {i_smp.mag_z[15], i_smp.mag_z} - {r_off_z[15], r_off_z};
        n_s0.sp = 17'sd0 - (w_axc <<< 1);
    end

    // ---------------- stage 1: 1 - sin^2(pitch) ----------------
    logic signed [33:0]    w_spsq;
    logic [SQ_REM_W-1:0]   r_v1;
    t_side                 r_s1;

    assign w_spsq = r_s0.sp * r_s0.sp;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0 <= n_s0;
            r_v1 <= SQ_REM_W'(34'sd1073741824 - w_spsq);
            r_s1 <= r_s0;
        end
    end

    // ---------------- cos(pitch) root chain ----------------
    logic [SQ_REM_W-1:0]  w_q1_rem  [ROOT_STEPS+1];
    logic [SQ_ROOT_W-1:0] w_q1_root [ROOT_STEPS+1];
    t_side                r_side_a  [ROOT_STEPS];

    assign w_q1_rem[0]  = r_v1;
    assign w_q1_root[0] = '0;

    for (genvar gk = 0; gk < ROOT_STEPS; gk++) begin : g_root1
        tcch_sqrt_cell #(.BIT_POS(SQ_TOP_BIT - 2 * gk)) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_rem  (w_q1_rem[gk]),
            .i_root (w_q1_root[gk]),
            .o_rem  (w_q1_rem[gk+1]),
            .o_root (w_q1_root[gk+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side_a[0] <= r_s1;
            for (int k = 1; k < ROOT_STEPS; k++) r_side_a[k] <= r_side_a[k-1];
        end
    end

    // ---------------- divider setup: roll clamp and zero checks ----------------
    logic [15:0]          w_cp;
    t_side                n_sd;
    t_side                r_sd;
    logic [DIV_REM_W-1:0] r_dd;

    always_comb begin
        w_cp          = w_q1_root[ROOT_STEPS][15:0];
        n_sd          = r_side_a[ROOT_STEPS-1];
        n_sd.cp       = w_cp;
        n_sd.sr_clamp = r_side_a[ROOT_STEPS-1].num > {1'b0, w_cp};
        n_sd.sr_zero  = w_cp == 16'd0;
        n_sd.flag     = r_side_a[ROOT_STEPS-1].flag
                        || (r_side_a[ROOT_STEPS-1].mode && n_sd.sr_clamp);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sd <= n_sd;
            r_dd <= DIV_REM_W'(r_side_a[ROOT_STEPS-1].num) << 15;
        end
    end

    // ---------------- sin(roll) divider chain ----------------
    logic [DIV_REM_W-1:0] w_dv_rem [DIV_STEPS+1];
    logic [DIV_DEN_W-1:0] w_dv_den [DIV_STEPS+1];
    logic [DIV_DEN_W-1:0] w_dv_quo [DIV_STEPS+1];
    t_side                r_side_b [DIV_STEPS];

    assign w_dv_rem[0] = r_dd;
    assign w_dv_den[0] = r_sd.cp;
    assign w_dv_quo[0] = '0;

    for (genvar gk = 0; gk < DIV_STEPS; gk++) begin : g_div
        tcch_div_cell #(.SHIFT(DIV_STEPS - 1 - gk)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_rem (w_dv_rem[gk]),
            .i_den (w_dv_den[gk]),
            .i_quo (w_dv_quo[gk]),
            .o_rem (w_dv_rem[gk+1]),
            .o_den (w_dv_den[gk+1]),
            .o_quo (w_dv_quo[gk+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side_b[0] <= r_sd;
            for (int k = 1; k < DIV_STEPS; k++) r_side_b[k] <= r_side_b[k-1];
        end
    end

    // ---------------- sin(roll) select, then 1 - sin^2(roll) ----------------
    logic [16:0]         w_sr_mag;
    t_side               n_ssr;
    t_side               r_ssr;
    logic signed [33:0]  w_srsq;
    logic [SQ_REM_W-1:0] r_v2;
    t_side               r_sv2;

    always_comb begin
        if (r_side_b[DIV_STEPS-1].sr_clamp) begin
            w_sr_mag = 17'd32768;
        end else if (r_side_b[DIV_STEPS-1].sr_zero) begin
            w_sr_mag = 17'd0;
        end else begin
            w_sr_mag = {1'b0, w_dv_quo[DIV_STEPS]};
        end
        n_ssr    = r_side_b[DIV_STEPS-1];
        n_ssr.sr = r_side_b[DIV_STEPS-1].ay_neg ? -signed'(w_sr_mag) : signed'(w_sr_mag);
    end

    assign w_srsq = r_ssr.sr * r_ssr.sr;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ssr <= n_ssr;
            r_v2  <= SQ_REM_W'(34'sd1073741824 - w_srsq);
            r_sv2 <= r_ssr;
        end
    end

    // ---------------- cos(roll) root chain ----------------
    logic [SQ_REM_W-1:0]  w_q2_rem  [ROOT_STEPS+1];
    logic [SQ_ROOT_W-1:0] w_q2_root [ROOT_STEPS+1];
    t_side                r_side_c  [ROOT_STEPS];

    assign w_q2_rem[0]  = r_v2;
    assign w_q2_root[0] = '0;

    for (genvar gk = 0; gk < ROOT_STEPS; gk++) begin : g_root2
        tcch_sqrt_cell #(.BIT_POS(SQ_TOP_BIT - 2 * gk)) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_rem  (w_q2_rem[gk]),
            .i_root (w_q2_root[gk]),
            .o_rem  (w_q2_rem[gk+1]),
            .o_root (w_q2_root[gk+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side_c[0] <= r_sv2;
            for (int k = 1; k < ROOT_STEPS; k++) r_side_c[k] <= r_side_c[k-1];
        end
    end

    // ---------------- field rotation into the horizontal plane ----------------
    t_side              w_rs;
    logic signed [16:0] w_cr_s;
    logic signed [33:0] r_pa;
    logic signed [33:0] r_pb;
    logic signed [33:0] r_pc;
    logic signed [33:0] r_pd;
    logic signed [33:0] r_pe;
    t_side              r_p1;
    logic signed [34:0] r_xs;
    logic signed [50:0] r_t1;
    logic signed [50:0] r_t3;
    logic signed [33:0] r_pd2;
    t_side              r_p2;
    logic signed [XW-1:0] n_x3;
    logic signed [XW-1:0] n_y3;
    logic signed [XW-1:0] r_x3;
    logic signed [XW-1:0] r_y3;
    logic                 r_f3;

    assign w_rs   = r_side_c[ROOT_STEPS-1];
    assign w_cr_s = signed'({1'b0, w_q2_root[ROOT_STEPS][15:0]});

    always_comb begin
        if (r_p2.mode) begin
            n_x3 = XW'(r_xs) <<< 15;
            n_y3 = XW'(r_t1) + (XW'(r_pd2) <<< 15) - XW'(r_t3);
        end else begin
            n_x3 = XW'(r_p2.mx) <<< 30;
            n_y3 = XW'(r_p2.my) <<< 30;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // first products
            r_pa  <= w_rs.mx * signed'({1'b0, w_rs.cp});
            r_pb  <= w_rs.mz * w_rs.sp;
            r_pc  <= w_rs.mx * w_rs.sr;
            r_pd  <= w_rs.my * w_cr_s;
            r_pe  <= w_rs.mz * w_rs.sr;
            r_p1  <= w_rs;
            // second products
            r_xs  <= 35'(r_pa) + 35'(r_pb);
            r_t1  <= r_pc * r_p1.sp;
            r_t3  <= r_pe * signed'({1'b0, r_p1.cp});
            r_pd2 <= r_pd;
            r_p2  <= r_p1;
            // horizontal vector, plain mode bypasses the rotation
            r_x3  <= n_x3;
            r_y3  <= n_y3;
            r_f3  <= r_p2.flag;
        end
    end

    // ---------------- CORDIC setup: half-plane fold ----------------
    logic signed [XW-1:0] r_cx;
    logic signed [XW-1:0] r_cy;
    logic signed [ZW-1:0] r_cz;
    t_cside               r_cs;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_cs.zero <= (r_x3 == '0) && (r_y3 == '0);
            r_cs.flag <= r_f3;
            if (r_x3[XW-1]) begin
                r_cx <= -r_x3;
                r_cy <= -r_y3;
                r_cz <= Z180;
            end else begin
                r_cx <= r_x3;
                r_cy <= r_y3;
                r_cz <= '0;
            end
        end
    end

    // ---------------- CORDIC chain ----------------
    logic signed [XW-1:0] w_cx [CORDIC_STAGES+1];
    logic signed [XW-1:0] w_cy [CORDIC_STAGES+1];
    logic signed [ZW-1:0] w_cz [CORDIC_STAGES+1];
    t_cside               r_cside [CORDIC_STAGES];

    assign w_cx[0] = r_cx;
    assign w_cy[0] = r_cy;
    assign w_cz[0] = r_cz;

    for (genvar gk = 0; gk < CORDIC_STAGES; gk++) begin : g_cordic
        tcch_cordic_cell #(.IDX(gk)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_x   (w_cx[gk]),
            .i_y   (w_cy[gk]),
            .i_z   (w_cz[gk]),
            .o_x   (w_cx[gk+1]),
            .o_y   (w_cy[gk+1]),
            .o_z   (w_cz[gk+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_cside[0] <= r_cs;
            for (int k = 1; k < CORDIC_STAGES; k++) r_cside[k] <= r_cside[k-1];
        end
    end

    // ---------------- wrap to one turn, round to 1/128 degree ----------------
    logic signed [ZW-1:0] w_zf;
    logic signed [ZW-1:0] n_zw;
    logic [24:0]          r_zw;
    t_cside               r_wside;
    logic [24:0]          w_rnd;
    logic [16:0]          w_q;
    logic [15:0]          n_head;
    logic [15:0]          r_head;
    logic                 r_flag;

    always_comb begin
        w_zf = w_cz[CORDIC_STAGES];
        if (w_zf[ZW-1]) begin
            n_zw = w_zf + Z360;
        end else if (w_zf >= Z360) begin
            n_zw = w_zf - Z360;
        end else begin
            n_zw = w_zf;
        end
    end

    always_comb begin
        w_rnd = r_zw + ROUND_HALF;
        w_q   = 17'(w_rnd >> 9);
        if (r_wside.zero) begin
            n_head = '0;
        end else if (w_q >= HEADING_WRAP) begin
            n_head = 16'(w_q - HEADING_WRAP);
        end else begin
            n_head = w_q[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_zw    <= n_zw[24:0];
            r_wside <= r_cside[CORDIC_STAGES-1];
            r_head  <= n_head;
            r_flag  <= r_wside.flag;
        end
    end

    assign o_hdg.valid         = r_vld[LAT-1];
    assign o_hdg.heading_angle = r_head;
    assign o_hdg.tilt_clamped  = r_flag;

endmodule
